[rtl/relativistic_primitive_to_conserved_macros.svh]
// ----------------------------------------------------------------------------
// relativistic_primitive_to_conserved_macros
// Assertion macros for the primitive-to-conserved block.
// ----------------------------------------------------------------------------
`ifndef RELATIVISTIC_PRIMITIVE_TO_CONSERVED_MACROS_SVH
`define RELATIVISTIC_PRIMITIVE_TO_CONSERVED_MACROS_SVH

`ifndef SYNTH

`define RP2C_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rp2c same-cycle check failed");

`define RP2C_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rp2c next-cycle check failed");

`else

`define RP2C_ASSERT_NOW(label, ante, cons)

`define RP2C_ASSERT_NEXT(label, ante, cons)

`endif

`endif

[rtl/rp2c_pkg.sv]
// ----------------------------------------------------------------------------
// rp2c_pkg
// Shared widths, latencies, register indexes and types.
// ----------------------------------------------------------------------------
package rp2c_pkg;

  localparam int RHO_W  = 31;
  localparam int U_W    = 32;
  localparam int P_W    = 31;
  localparam int GAM_W  = 18;
  localparam int F0_W   = 64;
  localparam int ROOT_W = F0_W / 2;
  localparam int PG_W   = P_W + GAM_W;
  localparam int NH_W   = 49;  // enthalpy clamped at 2^48 for momenta
  localparam int NHE_W  = 34;  // enthalpy clamped at 2^33 for energy
  localparam int TDATA_W = 160;

  localparam int SQRT_STAGES = F0_W / 2;
  localparam int DIV_STAGES  = PG_W;
  localparam int SIDE_DLY    = DIV_STAGES - 2;
  localparam int ROOT_DLY    = DIV_STAGES - 2 - SQRT_STAGES;
  localparam int POST_STAGES = 5;
  localparam int LAT         = 1 + DIV_STAGES + POST_STAGES;

  localparam logic [GAM_W-1:0] GAMMA_RESET = 18'd87381;
  localparam logic [GAM_W-1:0] Q_ONE       = 18'h10000;

  typedef enum logic [1:0] {
    REG_EOS_MODE    = 2'd0,
    REG_ENERGY_MODE = 2'd1,
    REG_GAMMA       = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic eos_mode;
    logic energy_mode;
  } mode_t;

  typedef struct packed {
    logic [F0_W-1:0]       f0;
    logic [2:0][U_W-1:0]   mag;
    logic [2:0]            neg;
    logic [RHO_W-1:0]      rho;
    logic [P_W-1:0]        p;
  } side_t;

  typedef struct packed {
    logic [RHO_W-1:0]      lab_density;
    logic [2:0][U_W-1:0]   mom;
    logic [U_W-1:0]        energy;
    logic                  overflow;
  } result_t;

endpackage

[rtl/rp2c_delay.sv]
// ----------------------------------------------------------------------------
// rp2c_delay
// Stall-aware shift line that keeps side data aligned with the long units.
// ----------------------------------------------------------------------------
module rp2c_delay #(
  parameter int W = 1,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] din,
  output logic [W-1:0] dout
);

  logic [W-1:0] tap [N];

  always_ff @(posedge clk) begin
    if (en) begin
      tap[0] <= din;
      for (int i = 1; i < N; i++) begin
        tap[i] <= tap[i-1];
      end
    end
  end

  assign dout = tap[N-1];

endmodule

[rtl/rp2c_isqrt.sv]
// ----------------------------------------------------------------------------
// rp2c_isqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module rp2c_isqrt #(
  parameter int IN_W = rp2c_pkg::F0_W
) (
  input  logic              clk,
  input  logic              en,
  input  logic [IN_W-1:0]   x,
  output logic [IN_W/2-1:0] root
);

  localparam int OUT_W = IN_W / 2;
  localparam int RW    = OUT_W + 3;

  logic [RW-1:0]    rem_r  [OUT_W];
  logic [OUT_W-1:0] root_r [OUT_W];
  logic [IN_W-1:0]  xs_r   [OUT_W];

  for (genvar k = 0; k < OUT_W; k++) begin : g_stage
    logic [RW-1:0]    rem_in;
    logic [RW-1:0]    rem_sh;
    logic [RW-1:0]    trial;
    logic [OUT_W-1:0] root_in;
    logic [IN_W-1:0]  xs_in;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign xs_in   = x;
    end else begin : g_rest
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign xs_in   = xs_r[k-1];
    end

    assign rem_sh = {rem_in[RW-3:0], xs_in[IN_W-1 -: 2]};
    assign trial  = {1'b0, root_in, 2'b01};

    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_sh >= trial) begin
          rem_r[k]  <= rem_sh - trial;
          root_r[k] <= {root_in[OUT_W-2:0], 1'b1};
        end else begin
          rem_r[k]  <= rem_sh;
          root_r[k] <= {root_in[OUT_W-2:0], 1'b0};
        end
        xs_r[k] <= {xs_in[IN_W-3:0], 2'b00};
      end
    end
  end

  assign root = root_r[OUT_W-1];

endmodule

[rtl/rp2c_div.sv]
// ----------------------------------------------------------------------------
// rp2c_div
// Pipelined restoring divider for the ideal-gas pressure term.
// ----------------------------------------------------------------------------
module rp2c_div (
  input  logic                       clk,
  input  logic                       en,
  input  logic [rp2c_pkg::PG_W-1:0]  dividend,
  input  logic [rp2c_pkg::GAM_W-1:0] divisor,
  output logic [rp2c_pkg::PG_W-1:0]  quotient
);

  import rp2c_pkg::*;

  localparam int N = DIV_STAGES;

  logic [GAM_W-1:0] rem_r [N];
  logic [N-1:0]     quo_r [N];
  logic [N-1:0]     num_r [N];
  logic [GAM_W:0]   dv;

  assign dv = {1'b0, divisor};

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [GAM_W-1:0] rem_in;
    logic [N-1:0]     quo_in;
    logic [N-1:0]     num_in;
    logic [GAM_W:0]   r2;
    logic [GAM_W:0]   diff;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign quo_in = '0;
      assign num_in = dividend;
    end else begin : g_rest
      assign rem_in = rem_r[k-1];
      assign quo_in = quo_r[k-1];
      assign num_in = num_r[k-1];
    end

    assign r2   = {rem_in, num_in[N-1]};
    assign diff = r2 - dv;

    always_ff @(posedge clk) begin
      if (en) begin
        if (r2 >= dv) begin
          rem_r[k] <= diff[GAM_W-1:0];
          quo_r[k] <= {quo_in[N-2:0], 1'b1};
        end else begin
          rem_r[k] <= r2[GAM_W-1:0];
          quo_r[k] <= {quo_in[N-2:0], 1'b0};
        end
        num_r[k] <= {num_in[N-2:0], 1'b0};
      end
    end
  end

  assign quotient = quo_r[N-1];

endmodule

[rtl/rp2c_post.sv]
// ----------------------------------------------------------------------------
// rp2c_post
// Enthalpy select, split products for D, K, momenta and energy, saturation.
// ----------------------------------------------------------------------------
module rp2c_post (
  input  logic                        clk,
  input  logic                        en,
  input  rp2c_pkg::mode_t             mode,
  input  logic [rp2c_pkg::PG_W-1:0]   q,
  input  logic [rp2c_pkg::ROOT_W-1:0] w,
  input  logic [rp2c_pkg::ROOT_W-1:0] sr,
  input  rp2c_pkg::side_t             side,
  output rp2c_pkg::result_t           res
);

  import rp2c_pkg::*;

  localparam int NHF_W = PG_W + 1;
  localparam int HI_W  = NH_W - 32;
  localparam int KH_W  = HI_W + ROOT_W;
  localparam int KS_W  = KH_W + 33;
  localparam int KQ_W  = KS_W - 16;
  localparam int TP_W  = NHE_W + 32;
  localparam int TS_W  = TP_W + 1;
  localparam int DM_W  = RHO_W + ROOT_W;
  localparam int D_W   = DM_W - 16;
  localparam int MH_W  = HI_W + U_W;
  localparam int MS_W  = MH_W + 33;
  localparam int MQ_W  = MS_W - 16;
  localparam int E_W   = NH_W + 2;

  localparam logic [NHF_W-1:0] NH_CAP  = NHF_W'(1) << (NH_W - 1);
  localparam logic [NHF_W-1:0] NHE_CAP = NHF_W'(1) << (NHE_W - 1);
  localparam logic [KQ_W-1:0]  K_CAP   = KQ_W'(1) << (NH_W - 1);
  localparam logic [TS_W-1:0]  T_CAP   = TS_W'(1) << (NH_W - 1);
  localparam logic [MQ_W-1:0]  M_POS   = MQ_W'(32'h7FFF_FFFF);
  localparam logic [MQ_W-1:0]  M_NEG   = MQ_W'(33'h1_0000_0000) >> 1;
  localparam logic signed [E_W-1:0] E_MAX = E_W'(32'sh7FFF_FFFF);
  localparam logic signed [E_W-1:0] E_MIN = -(E_W'(1) <<< 31);

  // P1: enthalpy
  logic [NHF_W-1:0] nh_ideal, nh_rel, nh_full;
  logic [NH_W-1:0]  nh1;
  logic [NHE_W-1:0] nhe1;
  logic [ROOT_W-1:0] w1;
  side_t            side1;

  always_comb begin
    nh_ideal = NHF_W'(side.rho) + NHF_W'(q);
    nh_rel   = NHF_W'((({3'b000, side.p} << 2) + {3'b000, side.p}) >> 1) + NHF_W'(sr);
    nh_full  = mode.eos_mode ? nh_rel : nh_ideal;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nh1   <= (nh_full > NH_CAP) ? NH_CAP[NH_W-1:0] : nh_full[NH_W-1:0];
      nhe1  <= (nh_full > NHE_CAP) ? NHE_CAP[NHE_W-1:0] : nh_full[NHE_W-1:0];
      w1    <= w;
      side1 <= side;
    end
  end

  // P2: partial products
  logic [63:0]        kl2;
  logic [KH_W-1:0]    kh2;
  logic [TP_W-1:0]    tl2, th2;
  logic [DM_W-1:0]    dm2;
  logic [2:0][U_W-1:0] mag2;
  logic [2:0]         neg2;
  logic [P_W-1:0]     p2;

  always_ff @(posedge clk) begin
    if (en) begin
      kl2  <= 64'(nh1[31:0]) * 64'(w1);
      kh2  <= KH_W'(nh1[NH_W-1:32]) * KH_W'(w1);
      tl2  <= TP_W'(nhe1) * TP_W'(side1.f0[31:0]);
      th2  <= TP_W'(nhe1) * TP_W'(side1.f0[63:32]);
      dm2  <= DM_W'(side1.rho) * DM_W'(w1);
      mag2 <= side1.mag;
      neg2 <= side1.neg;
      p2   <= side1.p;
    end
  end

  // P3: K, t, D
  logic [KS_W-1:0]  ksum;
  logic [KQ_W-1:0]  kq;
  logic [TS_W-1:0]  tsum;
  logic [NH_W-1:0]  k3, t3;
  logic [D_W-1:0]   d3;
  logic [2:0][U_W-1:0] mag3;
  logic [2:0]       neg3;
  logic [P_W-1:0]   p3;

  always_comb begin
    ksum = {1'b0, kh2, 32'h0} + KS_W'(kl2);
    kq   = ksum[KS_W-1:16];
    tsum = TS_W'(th2) + TS_W'(tl2[TP_W-1:32]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      k3   <= (kq > K_CAP) ? K_CAP[NH_W-1:0] : kq[NH_W-1:0];
      t3   <= (tsum > T_CAP) ? T_CAP[NH_W-1:0] : tsum[NH_W-1:0];
      d3   <= dm2[DM_W-1:16];
      mag3 <= mag2;
      neg3 <= neg2;
      p3   <= p2;
    end
  end

  // P4: momentum products, energy and D saturation
  logic signed [E_W-1:0] e;
  logic [U_W-1:0]        e_sat;
  logic                  e_ovf, d_ovf;
  logic [2:0][63:0]      ml4;
  logic [2:0][MH_W-1:0]  mh4;
  logic [2:0]            neg4;
  logic [U_W-1:0]        energy4;
  logic [RHO_W-1:0]      lab4;
  logic                  ovf4;

  always_comb begin
    e = $signed({2'b00, t3}) - $signed(E_W'(p3))
        - (mode.energy_mode ? $signed(E_W'(d3)) : $signed(E_W'(0)));
    e_ovf = 1'b1;
    if (e < E_MIN) begin
      e_sat = 32'h8000_0000;
    end else if (e > E_MAX) begin
      e_sat = 32'h7FFF_FFFF;
    end else begin
      e_sat = e[U_W-1:0];
      e_ovf = 1'b0;
    end
    d_ovf = (d3 > D_W'(31'h7FFF_FFFF));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        ml4[i] <= 64'(k3[31:0]) * 64'(mag3[i]);
        mh4[i] <= MH_W'(k3[NH_W-1:32]) * MH_W'(mag3[i]);
      end
      neg4    <= neg3;
      energy4 <= e_sat;
      lab4    <= d_ovf ? 31'h7FFF_FFFF : d3[RHO_W-1:0];
      ovf4    <= e_ovf | d_ovf;
    end
  end

  // P5: momentum sum and signed saturation
  logic [2:0][U_W-1:0] mom5;
  logic [2:0]          m_ovf;

  always_comb begin
    logic [MS_W-1:0] msum;
    logic [MQ_W-1:0] m;
    for (int i = 0; i < 3; i++) begin
      msum = {1'b0, mh4[i], 32'h0} + MS_W'(ml4[i]);
      m    = msum[MS_W-1:16];
      if (neg4[i]) begin
        m_ovf[i] = (m > M_NEG);
        mom5[i]  = m_ovf[i] ? 32'h8000_0000 : (~m[U_W-1:0] + 32'd1);
      end else begin
        m_ovf[i] = (m > M_POS);
        mom5[i]  = m_ovf[i] ? 32'h7FFF_FFFF : m[U_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res.lab_density <= lab4;
      res.mom         <= mom5;
      res.energy      <= energy4;
      res.overflow    <= ovf4 | (|m_ovf);
    end
  end

endmodule

[rtl/relativistic_primitive_to_conserved.sv]
// ----------------------------------------------------------------------------
// relativistic_primitive_to_conserved
// Converts one fluid cell's primitive state to lab-frame conserved variables.
// ----------------------------------------------------------------------------
// Takes one cell per clock while s_tready is high and returns one result per
// cell, in order, and stalls while the skid entry is full. The longest path
// is the 49-stage quotient pipeline for the ideal-gas enthalpy term, which runs
// beside two 32-stage square-root pipelines (Lorentz factor and the approximate
// relativistic enthalpy). A one-entry skid buffer behind the output register
// lets the whole pipeline keep running while one result waits downstream.
// Configuration must only be written while no cell is in flight.
`include "relativistic_primitive_to_conserved_macros.svh"

module relativistic_primitive_to_conserved (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // density, four_vel_x, four_vel_y, four_vel_z, pressure, zero pad
  input  logic [rp2c_pkg::TDATA_W-1:0] s_tdata,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // lab_density, mom_x, mom_y, mom_z, energy, zero pad
  output logic [rp2c_pkg::TDATA_W-1:0] m_tdata,
  // overflow
  output logic                         m_tuser,
  input  logic                         cfg_we,
  input  logic [1:0]                   cfg_index,
  input  logic [rp2c_pkg::GAM_W-1:0]   cfg_data
);

  import rp2c_pkg::*;

  // configuration
  logic             eos_mode, energy_mode;
  logic [GAM_W-1:0] gamma;
  logic [GAM_W-1:0] gm1;
  mode_t            mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      eos_mode    <= 1'b0;
      energy_mode <= 1'b0;
      gamma       <= GAMMA_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_EOS_MODE:    eos_mode    <= cfg_data[0];
        REG_ENERGY_MODE: energy_mode <= cfg_data[0];
        REG_GAMMA:       gamma       <= cfg_data;
        default: ;
      endcase
    end
  end

  assign gm1  = (gamma > Q_ONE) ? (gamma - Q_ONE) : GAM_W'(1);
  assign mode = '{eos_mode: eos_mode, energy_mode: energy_mode};

  // handshake and valid line
  logic         adv, accept, skid_valid, post_valid;
  logic [LAT:0] vld;

  assign adv      = !skid_valid;
  assign s_tready = adv;
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAT-1:0], accept};
    end
  end

  assign post_valid = vld[LAT];

  // stage 0: input register
  logic [RHO_W-1:0]    rho0;
  logic [P_W-1:0]      p0;
  logic [2:0][U_W-1:0] u0;

  always_ff @(posedge clk) begin
    if (adv) begin
      rho0  <= s_tdata[30:0];
      u0[0] <= s_tdata[62:31];
      u0[1] <= s_tdata[94:63];
      u0[2] <= s_tdata[126:95];
      p0    <= s_tdata[157:127];
    end
  end

  // stage 1: magnitudes and squares
  logic [2:0][U_W-1:0]  mag1;
  logic [2:0]           neg1;
  logic [2:0][F0_W-1:0] sq1;
  logic [PG_W-1:0]      pg1;
  logic [61:0]          pp1, rr1;
  logic [RHO_W-1:0]     rho1;
  logic [P_W-1:0]       p1;
  logic [2:0][U_W-1:0]  mag0;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag0[i] = u0[i][U_W-1] ? (~u0[i] + 32'd1) : u0[i];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        mag1[i] <= mag0[i];
        neg1[i] <= u0[i][U_W-1];
        sq1[i]  <= F0_W'(mag0[i]) * F0_W'(mag0[i]);
      end
      pg1  <= PG_W'(p0) * PG_W'(gamma);
      pp1  <= 62'(p0) * 62'(p0);
      rr1  <= 62'(rho0) * 62'(rho0);
      rho1 <= rho0;
      p1   <= p0;
    end
  end

  // stage 2: partial sums
  logic [F0_W-1:0]     a01, a2, s1, s2;
  logic [2:0][U_W-1:0] mag2;
  logic [2:0]          neg2;
  logic [RHO_W-1:0]    rho2;
  logic [P_W-1:0]      p2;
  logic [4:0]          pp_lo9;

  assign pp_lo9 = 5'({3'b000, pp1[1:0]} << 3) + 5'(pp1[1:0]);

  always_ff @(posedge clk) begin
    if (adv) begin
      a01  <= sq1[0] + sq1[1];
      a2   <= sq1[2] + 64'h1_0000_0000;
      s1   <= {1'b0, pp1[61:2], 3'b000} + F0_W'(pp1[61:2]);
      s2   <= F0_W'(rr1) + F0_W'(pp_lo9[4:2]);
      mag2 <= mag1;
      neg2 <= neg1;
      rho2 <= rho1;
      p2   <= p1;
    end
  end

  // stage 3: 1 + |u|^2 and the relativistic root argument
  logic [F0_W-1:0] f0_3, s_3;
  side_t           side3;

  always_ff @(posedge clk) begin
    if (adv) begin
      f0_3  <= a01 + a2;
      s_3   <= s1 + s2;
      side3.f0  <= a01 + a2;
      side3.mag <= mag2;
      side3.neg <= neg2;
      side3.rho <= rho2;
      side3.p   <= p2;
    end
  end

  // long units
  logic [ROOT_W-1:0] w_r, sr_r, w50, sr50;
  logic [PG_W-1:0]   q50;
  side_t             side50;

  rp2c_isqrt #(.IN_W(F0_W)) u_root_w (
    .clk  (clk),
    .en   (adv),
    .x    (f0_3),
    .root (w_r)
  );

  rp2c_isqrt #(.IN_W(F0_W)) u_root_s (
    .clk  (clk),
    .en   (adv),
    .x    (s_3),
    .root (sr_r)
  );

  rp2c_div u_div (
    .clk      (clk),
    .en       (adv),
    .dividend (pg1),
    .divisor  (gm1),
    .quotient (q50)
  );

  rp2c_delay #(.W($bits(side_t)), .N(SIDE_DLY)) u_side_dly (
    .clk  (clk),
    .en   (adv),
    .din  (side3),
    .dout (side50)
  );

  rp2c_delay #(.W(2*ROOT_W), .N(ROOT_DLY)) u_root_dly (
    .clk  (clk),
    .en   (adv),
    .din  ({w_r, sr_r}),
    .dout ({w50, sr50})
  );

  result_t post_res;

  rp2c_post u_post (
    .clk  (clk),
    .en   (adv),
    .mode (mode),
    .q    (q50),
    .w    (w50),
    .sr   (sr50),
    .side (side50),
    .res  (post_res)
  );

  // output register and skid entry
  result_t out_res, skid_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (m_tready) begin
        skid_valid <= 1'b0;
      end
    end else if (post_valid) begin
      if (!m_tvalid || m_tready) begin
        m_tvalid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (m_tready) begin
        out_res <= skid_res;
      end
    end else if (post_valid) begin
      if (!m_tvalid || m_tready) begin
        out_res <= post_res;
      end else begin
        skid_res <= post_res;
      end
    end
  end

  assign m_tdata = {1'b0, out_res.energy, out_res.mom[2], out_res.mom[1], out_res.mom[0],
                    out_res.lab_density};
  assign m_tuser = out_res.overflow;

  `RP2C_ASSERT_NOW(a_skid_behind_out, skid_valid, m_tvalid)
  `RP2C_ASSERT_NEXT(a_skid_holds, skid_valid && !m_tready, skid_valid && m_tvalid)
  `RP2C_ASSERT_NEXT(a_result_parked, post_valid && !skid_valid && m_tvalid && !m_tready,
                    skid_valid)

endmodule
